// File: src/cdf_pkg.sv
`timescale 1ns / 1ps
package cdf_pkg;

   // Operation codes carried on the request channel
   localparam logic [1:0] OP_WRITE_WEIGHT     = 2'd0;
   localparam logic [1:0] OP_WRITE_BIAS       = 2'd1;
   localparam logic [1:0] OP_WRITE_ACTIVATION = 2'd2;
   localparam logic [1:0] OP_COMPUTE          = 2'd3;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 7;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INPUT_CHANNELS  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_CHANNELS = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KERNEL_SIDE     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STRIDE_STEP     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAD_AMOUNT      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_HEIGHT    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_WIDTH     = 3'd6;

   typedef struct packed {
      logic [1:0]         operation;
      logic [15:0]        store_index;
      logic signed [15:0] sample_value;
      logic signed [31:0] bias_value;
      logic [3:0]         target_channel;
      logic [5:0]         target_row;
      logic [5:0]         target_col;
   } req_type;

   typedef struct packed {
      logic signed [47:0] conv_result;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic [4:0] input_channel_count;
      logic [4:0] output_channel_count;
      logic [2:0] kernel_side;
      logic [2:0] stride_step;
      logic [1:0] pad_amount;
      logic [6:0] image_height;
      logic [6:0] image_width;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      input_channel_count:  5'd1,
      output_channel_count: 5'd1,
      kernel_side:          3'd3,
      stride_step:          3'd1,
      pad_amount:           2'd0,
      image_height:         7'd64,
      image_width:          7'd64
   };

   // Commands from the controller to the datapath
   typedef struct packed {
      logic take;      // request transfer this cycle
      logic setup1;    // geometry check, first products
      logic setup2;    // base addresses
      logic init;      // clear tap counters, load bias
      logic step;      // issue one tap
      logic out_load;  // capture result into output register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic geom_ok;
      logic last_tap;
   } sts_type;

endpackage

// File: src/cdf_ram.sv
`timescale 1ns / 1ps
module cdf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/cdf_ctrl.sv
`timescale 1ns / 1ps
module cdf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_op,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  cdf_pkg::sts_type sts,
   output cdf_pkg::cmd_type cmd
);
   import cdf_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP1 = 3'd1;
   localparam logic [2:0] ST_SETUP2 = 3'd2;
   localparam logic [2:0] ST_SETUP3 = 3'd3;
   localparam logic [2:0] ST_RUN    = 3'd4;
   localparam logic [2:0] ST_DRAIN1 = 3'd5;
   localparam logic [2:0] ST_DRAIN2 = 3'd6;
   localparam logic [2:0] ST_FINISH = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       take;
   logic       slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign take      = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Sequence one compute: setup, tap loop, drain, result; a rejected request goes from setup to result
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.take     = take;
      case (state_ff)
         ST_IDLE: begin
            if (take && req_op == OP_COMPUTE) begin
               state_in = ST_SETUP1;
            end
         end
         ST_SETUP1: begin
            cmd.setup1 = 1'b1;
            state_in   = ST_SETUP2;
         end
         ST_SETUP2: begin
            cmd.setup2 = 1'b1;
            state_in   = sts.geom_ok ? ST_SETUP3 : ST_FINISH;
         end
         ST_SETUP3: begin
            cmd.init = 1'b1;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (sts.last_tap) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: state_in = ST_DRAIN2;
         ST_DRAIN2: state_in = ST_FINISH;
         ST_FINISH: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result raised outside finish");

   a_compute_starts: assert property (@(posedge clock) disable iff (reset)
      (take && req_op == OP_COMPUTE) |=> state_ff == ST_SETUP1)
      else $error("compute transfer did not start setup");

   a_finish_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_ready) |=> state_ff == ST_FINISH)
      else $error("result overwritten while output stalled");

endmodule

// File: src/cdf_datapath.sv
`timescale 1ns / 1ps
module cdf_datapath #(
   parameter int MAX_IN_CHANNELS  = 16,
   parameter int MAX_OUT_CHANNELS = 16,
   parameter int MAX_KERNEL       = 7,
   parameter int MAX_HEIGHT       = 64,
   parameter int MAX_WIDTH        = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [cdf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [cdf_pkg::CSR_DATA_WIDTH-1:0]    csr_data,
   input  cdf_pkg::req_type                      req_data,
   input  cdf_pkg::cmd_type                      cmd,
   output cdf_pkg::sts_type                      sts,
   output cdf_pkg::rsp_type                      rsp_data
);
   import cdf_pkg::*;

   localparam int WEIGHT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
   localparam int ACT_DEPTH    = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
   localparam int WAW = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
   localparam int AAW = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
   localparam int BAW = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
   // signed activation address arithmetic, room for negative row offsets
   localparam int AAS = (AAW + 2 > 18) ? AAW + 2 : 18;

   // Configuration
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_INPUT_CHANNELS:  cfg_ff.input_channel_count  <= csr_data[4:0];
            CSR_OUTPUT_CHANNELS: cfg_ff.output_channel_count <= csr_data[4:0];
            CSR_KERNEL_SIDE:     cfg_ff.kernel_side          <= csr_data[2:0];
            CSR_STRIDE_STEP:     cfg_ff.stride_step          <= csr_data[2:0];
            CSR_PAD_AMOUNT:      cfg_ff.pad_amount           <= csr_data[1:0];
            CSR_IMAGE_HEIGHT:    cfg_ff.image_height         <= csr_data[6:0];
            CSR_IMAGE_WIDTH:     cfg_ff.image_width          <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   logic [4:0] icn;
   logic [4:0] ocn;
   logic [2:0] ksz;
   logic [2:0] stp;
   logic [1:0] pad;
   logic [6:0] hgt;
   logic [6:0] wid;

   assign icn = cfg_ff.input_channel_count;
   assign ocn = cfg_ff.output_channel_count;
   assign ksz = cfg_ff.kernel_side;
   assign stp = cfg_ff.stride_step;
   assign pad = cfg_ff.pad_amount;
   assign hgt = cfg_ff.image_height;
   assign wid = cfg_ff.image_width;

   // Store writes
   logic            we_weight;
   logic            we_bias;
   logic            we_act;
   logic [31:0]     idx_ext;

   assign idx_ext   = {16'b0, req_data.store_index};
   assign we_weight = cmd.take && req_data.operation == OP_WRITE_WEIGHT
                      && idx_ext < 32'(WEIGHT_DEPTH);
   assign we_bias   = cmd.take && req_data.operation == OP_WRITE_BIAS
                      && idx_ext < 32'(MAX_OUT_CHANNELS);
   assign we_act    = cmd.take && req_data.operation == OP_WRITE_ACTIVATION
                      && idx_ext < 32'(ACT_DEPTH);

   // Latch request coordinates
   logic [3:0] oc_ff;
   logic [5:0] orow_ff;
   logic [5:0] ocol_ff;

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         oc_ff   <= req_data.target_channel;
         orow_ff <= req_data.target_row;
         ocol_ff <= req_data.target_col;
      end
   end

   // Geometry check and first products
   logic [10:0]        orow_s;
   logic [10:0]        ocol_s;
   logic signed [8:0]  xh;
   logic signed [8:0]  xw;
   logic               geom_ok;
   logic               map_ok;
   logic [13:0]        hw_u;
   logic               ok_ff;
   logic signed [10:0] r0_ff;
   logic signed [10:0] c0_ff;
   logic [5:0]         kk_ff;
   logic signed [AAS-1:0] hw_ff;
   logic [8:0]         ocn_icn_ff;

   assign orow_s = 11'(orow_ff) * 11'(stp);
   assign ocol_s = 11'(ocol_ff) * 11'(stp);
   assign xh     = $signed({2'b0, hgt}) + $signed({6'b0, pad, 1'b0}) - $signed({6'b0, ksz});
   assign xw     = $signed({2'b0, wid}) + $signed({6'b0, pad, 1'b0}) - $signed({6'b0, ksz});
   assign geom_ok = icn != 5'd0 && int'(icn) <= MAX_IN_CHANNELS
                    && ocn != 5'd0 && int'(ocn) <= MAX_OUT_CHANNELS
                    && ksz != 3'd0 && int'(ksz) <= MAX_KERNEL
                    && stp != 3'd0
                    && hgt != 7'd0 && int'(hgt) <= MAX_HEIGHT
                    && wid != 7'd0 && int'(wid) <= MAX_WIDTH
                    && xh >= 9'sd0 && xw >= 9'sd0;
   assign map_ok  = {1'b0, oc_ff} < ocn
                    && $signed({1'b0, orow_s}) <= 12'(xh)
                    && $signed({1'b0, ocol_s}) <= 12'(xw);
   assign hw_u    = 14'(hgt) * 14'(wid);

   always_ff @(posedge clock) begin
      if (cmd.setup1) begin
         ok_ff      <= geom_ok && map_ok;
         r0_ff      <= $signed(orow_s) - $signed(11'(pad));
         c0_ff      <= $signed(ocol_s) - $signed(11'(pad));
         kk_ff      <= 6'(ksz) * 6'(ksz);
         hw_ff      <= AAS'($signed({1'b0, hw_u}));
         ocn_icn_ff <= 9'(oc_ff) * 9'(icn);
      end
   end

   // Base addresses
   logic [WAW-1:0]        wbase_ff;
   logic signed [AAS-1:0] r0w_ff;
   logic signed [17:0]    r0w_prod;

   assign r0w_prod = 18'(r0_ff) * $signed({11'b0, wid});

   always_ff @(posedge clock) begin
      if (cmd.setup2) begin
         wbase_ff <= WAW'(15'(ocn_icn_ff) * 15'(kk_ff));
         r0w_ff   <= AAS'(r0w_prod);
      end
   end

   // Tap counters and running addresses
   logic [4:0]            ic_ff, ic_in;
   logic [2:0]            kh_ff, kh_in;
   logic [2:0]            kw_ff, kw_in;
   logic signed [10:0]    r_ff, r_in;
   logic signed [10:0]    c_ff, c_in;
   logic [WAW-1:0]        wa_ff, wa_in;
   logic signed [AAS-1:0] plane_ff, plane_in;
   logic signed [AAS-1:0] row_ff, row_in;
   logic signed [AAS-1:0] wid_s;
   logic                  last_kw;
   logic                  last_kh;
   logic                  last_ic;

   assign wid_s   = AAS'($signed({1'b0, wid}));
   assign last_kw = kw_ff == ksz - 3'd1;
   assign last_kh = kh_ff == ksz - 3'd1;
   assign last_ic = ic_ff == icn - 5'd1;

   always_comb begin
      ic_in    = ic_ff;
      kh_in    = kh_ff;
      kw_in    = kw_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      wa_in    = wa_ff;
      plane_in = plane_ff;
      row_in   = row_ff;
      if (cmd.init) begin
         ic_in    = '0;
         kh_in    = '0;
         kw_in    = '0;
         r_in     = r0_ff;
         c_in     = c0_ff;
         wa_in    = wbase_ff;
         plane_in = '0;
         row_in   = r0w_ff;
      end else if (cmd.step) begin
         wa_in = wa_ff + WAW'(1);
         if (last_kw) begin
            kw_in = '0;
            c_in  = c0_ff;
            if (last_kh) begin
               kh_in    = '0;
               r_in     = r0_ff;
               ic_in    = ic_ff + 5'd1;
               plane_in = plane_ff + hw_ff;
               row_in   = plane_ff + hw_ff + r0w_ff;
            end else begin
               kh_in  = kh_ff + 3'd1;
               r_in   = r_ff + 11'sd1;
               row_in = row_ff + wid_s;
            end
         end else begin
            kw_in = kw_ff + 3'd1;
            c_in  = c_ff + 11'sd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      ic_ff    <= ic_in;
      kh_ff    <= kh_in;
      kw_ff    <= kw_in;
      r_ff     <= r_in;
      c_ff     <= c_in;
      wa_ff    <= wa_in;
      plane_ff <= plane_in;
      row_ff   <= row_in;
   end

   // Drop taps that fall in the zero border
   logic                  tap_ok;
   logic signed [AAS-1:0] act_addr;

   assign tap_ok   = r_ff >= 11'sd0 && r_ff < $signed({4'b0, hgt})
                     && c_ff >= 11'sd0 && c_ff < $signed({4'b0, wid});
   assign act_addr = row_ff + AAS'(c_ff);

   // Stores
   logic [15:0] weight_rd;
   logic [31:0] bias_rd;
   logic [15:0] act_rd;

   cdf_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (we_weight),
      .wr_addr (WAW'(idx_ext)),
      .wr_data (req_data.sample_value),
      .rd_addr (wa_ff),
      .rd_data (weight_rd)
   );

   cdf_ram #(.WIDTH(32), .DEPTH(MAX_OUT_CHANNELS)) u_bias_ram (
      .clock   (clock),
      .wr_en   (we_bias),
      .wr_addr (BAW'(idx_ext)),
      .wr_data (req_data.bias_value),
      .rd_addr (BAW'(32'(oc_ff))),
      .rd_data (bias_rd)
   );

   cdf_ram #(.WIDTH(16), .DEPTH(ACT_DEPTH)) u_act_ram (
      .clock   (clock),
      .wr_en   (we_act),
      .wr_addr (AAW'(idx_ext)),
      .wr_data (req_data.sample_value),
      .rd_addr (act_addr[AAW-1:0]),
      .rd_data (act_rd)
   );

   // Multiply-accumulate pipeline: read, product, accumulate
   logic               vld1_ff;
   logic               vld2_ff;
   logic signed [31:0] prod_ff;
   logic signed [47:0] acc_ff;
   logic signed [48:0] sum;
   logic signed [47:0] acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         vld1_ff <= cmd.step && tap_ok;
         vld2_ff <= vld1_ff;
      end
   end

   assign sum = 49'(acc_ff) + 49'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (cmd.init) begin
         acc_in = 48'($signed(bias_rd));
      end else if (vld2_ff) begin
         // saturate to the signed 48-bit range
         if (sum[48] != sum[47]) begin
            acc_in = sum[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
         end else begin
            acc_in = sum[47:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= $signed(weight_rd) * $signed(act_rd);
      acc_ff  <= acc_in;
   end

   // Output register
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.conv_result <= ok_ff ? acc_ff : '0;
         rsp_ff.status      <= !ok_ff;
      end
   end

   assign rsp_data     = rsp_ff;
   assign sts.geom_ok  = ok_ff;
   assign sts.last_tap = last_ic && last_kh && last_kw;

   a_init_needs_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.init |-> ok_ff)
      else $error("tap loop started on a rejected request");

   a_step_needs_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> ok_ff)
      else $error("tap issued on a rejected request");

   a_drained_on_load: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !vld1_ff && !vld2_ff)
      else $error("result captured before the pipeline drained");

endmodule

// File: src/conv2d_direct_forward_core.sv
`timescale 1ns / 1ps
// Direct 2D convolution engine for one image. Weight, bias and activation
// transfers fill on-chip stores, one per cycle while no compute is in progress;
// stores hold no reset value and must be written before they are read. A
// compute transfer returns the sum of activation times weight over input
// channels and kernel taps plus the bias, saturated to 48 bits, or status 1
// when the request or geometry is out of range. One shared multiply-accumulate
// unit reads one weight and one activation per cycle; no new request is taken
// until the compute is through, and a rejected request skips the tap loop. The
// result sits in an output register, so a new request is taken while it
// waits. The user must write configuration only while idle; no logic enforces it.
module conv2d_direct_forward_core #(
   parameter int MAX_IN_CHANNELS  = 16,
   parameter int MAX_OUT_CHANNELS = 16,
   parameter int MAX_KERNEL       = 7,
   parameter int MAX_HEIGHT       = 64,
   parameter int MAX_WIDTH        = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cdf_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cdf_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cdf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cdf_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import cdf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Register writes are always accepted
   assign csr_ready = 1'b1;

   cdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_data.operation),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cdf_datapath #(
      .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
      .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
      .MAX_KERNEL       (MAX_KERNEL),
      .MAX_HEIGHT       (MAX_HEIGHT),
      .MAX_WIDTH        (MAX_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sim/conv2d_checker.sv
`timescale 1ns / 1ps
module conv2d_checker #(
   parameter int MAX_IN_CHANNELS  = 16,
   parameter int MAX_OUT_CHANNELS = 16,
   parameter int MAX_KERNEL       = 7,
   parameter int MAX_HEIGHT       = 64,
   parameter int MAX_WIDTH        = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  cdf_pkg::req_type                    req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  cdf_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [cdf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [cdf_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                  mismatch_count,
   output int                                  outstanding,
   output int                                  checked_count,
   output int                                  reject_count
);
   import cdf_pkg::*;

   localparam int WEIGHT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
   localparam int ACT_DEPTH    = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
   localparam longint SUM_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_MIN  = -SUM_MAX - 1;

   // Mirrors of the on-chip stores and the geometry registers
   logic [15:0] weight_mem [WEIGHT_DEPTH];
   logic [31:0] bias_mem [MAX_OUT_CHANNELS];
   logic [15:0] act_mem [ACT_DEPTH];
   cfg_type     geom;

   // Predicted results, oldest first
   rsp_type pixel_q [$];

   // Work out one output pixel: bias plus the sum over channels and taps in the image
   function automatic rsp_type predict_pixel(input req_type rq);
      rsp_type res;
      int      ic_n, oc_n, k, s, p, h, w, oh, ow, oc, orow, ocol;
      int      ic, kh, kw, r, c, wa, aa;
      longint  acc;
      res.conv_result = '0;
      res.status      = 1'b1;
      ic_n = geom.input_channel_count;
      oc_n = geom.output_channel_count;
      k    = geom.kernel_side;
      s    = geom.stride_step;
      p    = geom.pad_amount;
      h    = geom.image_height;
      w    = geom.image_width;
      oc   = rq.target_channel;
      orow = rq.target_row;
      ocol = rq.target_col;
      if (ic_n < 1 || ic_n > MAX_IN_CHANNELS || oc_n < 1 || oc_n > MAX_OUT_CHANNELS)
         return res;
      if (k < 1 || k > MAX_KERNEL || s < 1 || h < 1 || h > MAX_HEIGHT || w < 1 || w > MAX_WIDTH)
         return res;
      if (k > h + 2 * p || k > w + 2 * p)
         return res;
      oh = (h + 2 * p - k) / s + 1;
      ow = (w + 2 * p - k) / s + 1;
      if (oc >= oc_n || orow >= oh || ocol >= ow)
         return res;

      acc = longint'($signed(bias_mem[oc]));
      for (ic = 0; ic < ic_n; ic++) begin
         for (kh = 0; kh < k; kh++) begin
            r = orow * s + kh - p;
            if (r < 0 || r >= h)
               continue;
            for (kw = 0; kw < k; kw++) begin
               c = ocol * s + kw - p;
               if (c < 0 || c >= w)
                  continue;
               wa = ((oc * ic_n + ic) * k + kh) * k + kw;
               aa = (ic * h + r) * w + c;
               if (wa >= WEIGHT_DEPTH || aa >= ACT_DEPTH)
                  continue;
               acc += longint'($signed(weight_mem[wa])) * longint'($signed(act_mem[aa]));
               // saturate to the 48-bit result range
               if (acc > SUM_MAX) acc = SUM_MAX;
               if (acc < SUM_MIN) acc = SUM_MIN;
            end
         end
      end
      res.conv_result = acc[47:0];
      res.status      = 1'b0;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         geom = CFG_RESET;
         pixel_q.delete();
         mismatch_count = 0;
         checked_count  = 0;
         reject_count   = 0;
      end else begin
         // Compare a result transfer with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (pixel_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: conv_result %0d status %0d",
                           rsp_data.conv_result, rsp_data.status);
            end else begin
               want = pixel_q.pop_front();
               checked_count++;
               if (want.status)
                  reject_count++;
               if (rsp_data.conv_result !== want.conv_result ||
                   rsp_data.status !== want.status) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result %0d: expected conv_result %0d status %0d, got %0d status %0d",
                              checked_count, want.conv_result, want.status,
                              rsp_data.conv_result, rsp_data.status);
               end
            end
         end

         // Apply a request transfer: fill a store or predict a pixel
         if (req_valid && req_ready) begin
            case (req_data.operation)
               OP_WRITE_WEIGHT: begin
                  if (req_data.store_index < WEIGHT_DEPTH)
                     weight_mem[req_data.store_index] = req_data.sample_value;
               end
               OP_WRITE_BIAS: begin
                  if (req_data.store_index < MAX_OUT_CHANNELS)
                     bias_mem[req_data.store_index] = req_data.bias_value;
               end
               OP_WRITE_ACTIVATION: begin
                  if (req_data.store_index < ACT_DEPTH)
                     act_mem[req_data.store_index] = req_data.sample_value;
               end
               OP_COMPUTE: begin
                  pixel_q.push_back(predict_pixel(req_data));
               end
            endcase
         end

         // Track register writes, masked to each register's width
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INPUT_CHANNELS:  geom.input_channel_count  = csr_data[4:0];
               CSR_OUTPUT_CHANNELS: geom.output_channel_count = csr_data[4:0];
               CSR_KERNEL_SIDE:     geom.kernel_side          = csr_data[2:0];
               CSR_STRIDE_STEP:     geom.stride_step          = csr_data[2:0];
               CSR_PAD_AMOUNT:      geom.pad_amount           = csr_data[1:0];
               CSR_IMAGE_HEIGHT:    geom.image_height         = csr_data[6:0];
               CSR_IMAGE_WIDTH:     geom.image_width          = csr_data[6:0];
               default: ;
            endcase
         end
      end
      outstanding = pixel_q.size();
   end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;
   import cdf_pkg::*;

   localparam int WEIGHT_DEPTH = 16 * 16 * 7 * 7;
   localparam int ACT_DEPTH    = 16 * 64 * 64;
   localparam int BIAS_DEPTH   = 16;
   // Index with no register behind it
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE = 3'd7;

   logic                       clock;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   req_type                    req_data  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data  = '0;

   int mismatch_count, outstanding, checked_count, reject_count;

   // Entries written so far: a compute may only read these
   bit      weight_done [WEIGHT_DEPTH];
   bit      act_done [ACT_DEPTH];
   bit      bias_done [BIAS_DEPTH];
   cfg_type geom = CFG_RESET;

   int burst_left    = 0;
   int sent_count    = 0;
   int compute_count = 0;
   int setting_count = 0;

   bit [7:0] stall_clock = '0;
   int       stall_mode  = 0;

   // Odd geometries: a zero register, a register over its maximum, a kernel wider
   // than the padded image, and a legal one with the widest stride
   int odd_geoms [14][7] = '{
      '{0, 1, 1, 1, 0, 4, 4},   '{1, 0, 1, 1, 0, 4, 4},   '{1, 1, 0, 1, 0, 4, 4},
      '{1, 1, 1, 0, 0, 4, 4},   '{1, 1, 1, 1, 0, 0, 4},   '{1, 1, 1, 1, 0, 4, 0},
      '{17, 1, 1, 1, 0, 4, 4},  '{31, 2, 1, 1, 0, 4, 4},  '{1, 17, 1, 1, 0, 4, 4},
      '{1, 1, 1, 1, 0, 65, 4},  '{1, 1, 1, 1, 0, 4, 127}, '{1, 1, 7, 1, 0, 6, 64},
      '{1, 1, 5, 1, 1, 64, 2},  '{2, 2, 3, 7, 1, 9, 9}
   };

   conv2d_direct_forward_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   conv2d_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .checked_count  (checked_count),
      .reject_count   (reject_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stall the result side in modes that change when the stall counter wraps: open, patchy, mostly shut
   always @(posedge clock) begin
      stall_clock <= stall_clock + 8'd1;
      if (stall_clock == 8'd0)
         stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 2) != 0);
         default: rsp_ready <= ($urandom_range(0, 11) == 0);
      endcase
   end

   // Send one request transfer; bursts of random length with gaps between them
   task automatic send_req(input req_type item);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 60)) @(posedge clock);
         else
            repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   function automatic req_type random_item();
      logic [95:0] noise;
      noise = {$urandom, $urandom, $urandom};
      return noise[$bits(req_type)-1:0];
   endfunction

   // Write one store entry with given values; the unused fields stay random
   task automatic store_value(input logic [1:0] op, input int idx, input logic [15:0] sample,
                              input logic [31:0] bias);
      req_type item;
      item = random_item();
      item.operation    = op;
      item.store_index  = 16'(idx);
      item.sample_value = sample;
      item.bias_value   = bias;
      send_req(item);
      if (op == OP_WRITE_WEIGHT && idx < WEIGHT_DEPTH)
         weight_done[idx] = 1'b1;
      if (op == OP_WRITE_BIAS && idx < BIAS_DEPTH)
         bias_done[idx] = 1'b1;
      if (op == OP_WRITE_ACTIVATION && idx < ACT_DEPTH)
         act_done[idx] = 1'b1;
   endtask

   // Write one store entry with random values, leaning now and then to the extremes
   task automatic store_write(input logic [1:0] op, input int idx);
      logic [15:0] sample;
      logic [31:0] bias;
      sample = 16'($urandom);
      bias   = $urandom;
      case ($urandom_range(0, 7))
         0: begin sample = 16'h8000; bias = 32'h8000_0000; end
         1: begin sample = 16'h7FFF; bias = 32'h7FFF_FFFF; end
         default: ;
      endcase
      store_value(op, idx, sample, bias);
   endtask

   function automatic bit geometry_ok(output int oh, output int ow);
      int ic_n, oc_n, k, s, p, h, w;
      ic_n = geom.input_channel_count;
      oc_n = geom.output_channel_count;
      k    = geom.kernel_side;
      s    = geom.stride_step;
      p    = geom.pad_amount;
      h    = geom.image_height;
      w    = geom.image_width;
      oh   = 0;
      ow   = 0;
      if (ic_n < 1 || ic_n > 16 || oc_n < 1 || oc_n > 16 || k < 1 || k > 7 || s < 1)
         return 1'b0;
      if (h < 1 || h > 64 || w < 1 || w > 64 || k > h + 2 * p || k > w + 2 * p)
         return 1'b0;
      oh = (h + 2 * p - k) / s + 1;
      ow = (w + 2 * p - k) / s + 1;
      return 1'b1;
   endfunction

   function automatic bit pixel_in_map(input int oc, input int row, input int col);
      int oh, ow;
      if (!geometry_ok(oh, ow))
         return 1'b0;
      return oc < geom.output_channel_count && row < oh && col < ow;
   endfunction

   // Ask for one pixel; first fill every entry that it reads and that is still unwritten
   task automatic request_pixel(input int oc, input int row, input int col);
      int      ic, kh, kw, r, c, wa, aa, ic_n, k, s, p, h, w;
      req_type item;
      ic_n = geom.input_channel_count;
      k    = geom.kernel_side;
      s    = geom.stride_step;
      p    = geom.pad_amount;
      h    = geom.image_height;
      w    = geom.image_width;
      if (pixel_in_map(oc, row, col)) begin
         if (!bias_done[oc])
            store_write(OP_WRITE_BIAS, oc);
         for (ic = 0; ic < ic_n; ic++)
            for (kh = 0; kh < k; kh++)
               for (kw = 0; kw < k; kw++) begin
                  r = row * s + kh - p;
                  c = col * s + kw - p;
                  if (r >= 0 && r < h && c >= 0 && c < w) begin
                     wa = ((oc * ic_n + ic) * k + kh) * k + kw;
                     aa = (ic * h + r) * w + c;
                     if (!weight_done[wa])
                        store_write(OP_WRITE_WEIGHT, wa);
                     if (!act_done[aa])
                        store_write(OP_WRITE_ACTIVATION, aa);
                  end
               end
      end
      item = random_item();
      item.operation      = OP_COMPUTE;
      item.target_channel = 4'(oc);
      item.target_row     = 6'(row);
      item.target_col     = 6'(col);
      send_req(item);
      compute_count++;
   endtask

   // A pixel inside the map where there is one, else anywhere
   task automatic pixel_somewhere();
      int oh, ow;
      if (geometry_ok(oh, ow))
         request_pixel($urandom_range(0, geom.output_channel_count - 1),
                       $urandom_range(0, (oh > 64 ? 64 : oh) - 1),
                       $urandom_range(0, (ow > 64 ? 64 : ow) - 1));
      else
         request_pixel($urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 63));
   endtask

   // Drop valid, wait for every result, then let the block go quiet
   task automatic settle(input int tail);
      req_valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (outstanding != 0);
      repeat (tail) @(posedge clock);
   endtask

   // One register write; bits above the register's width carry junk
   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input int value,
                            input int width);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_WIDTH'(($urandom << width) | (value & ((1 << width) - 1)));
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_geometry(input int ic, input int oc, input int k, input int s,
                               input int p, input int h, input int w);
      settle(20);
      write_reg(CSR_INPUT_CHANNELS, ic, 5);
      write_reg(CSR_OUTPUT_CHANNELS, oc, 5);
      write_reg(CSR_KERNEL_SIDE, k, 3);
      write_reg(CSR_STRIDE_STEP, s, 3);
      write_reg(CSR_PAD_AMOUNT, p, 2);
      write_reg(CSR_IMAGE_HEIGHT, h, 7);
      write_reg(CSR_IMAGE_WIDTH, w, 7);
      geom.input_channel_count  = 5'(ic);
      geom.output_channel_count = 5'(oc);
      geom.kernel_side          = 3'(k);
      geom.stride_step          = 3'(s);
      geom.pad_amount           = 2'(p);
      geom.image_height         = 7'(h);
      geom.image_width          = 7'(w);
      setting_count++;
   endtask

   // Mostly well-formed pixel requests, with rewrites, bias updates and noise
   task automatic random_traffic(input int count);
      int i, pick, tries, oc, row, col, span;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            pixel_somewhere();
         end else if (pick < 65) begin
            // aim outside the map
            tries = 0;
            do begin
               oc  = $urandom_range(0, 15);
               row = $urandom_range(0, 63);
               col = $urandom_range(0, 63);
               tries++;
            end while (pixel_in_map(oc, row, col) && tries < 20);
            request_pixel(oc, row, col);
         end else if (pick < 72) begin
            span = geom.output_channel_count * geom.input_channel_count *
                   geom.kernel_side * geom.kernel_side;
            span = (span < 1) ? 1 : (span > WEIGHT_DEPTH ? WEIGHT_DEPTH : span);
            store_write(OP_WRITE_WEIGHT, $urandom_range(0, span - 1));
         end else if (pick < 79) begin
            span = geom.input_channel_count * geom.image_height * geom.image_width;
            span = (span < 1) ? 1 : (span > ACT_DEPTH ? ACT_DEPTH : span);
            store_write(OP_WRITE_ACTIVATION, $urandom_range(0, span - 1));
         end else if (pick < 88) begin
            if ($urandom_range(0, 3) == 0)
               store_write(OP_WRITE_BIAS, $urandom_range(0, 65535));
            else
               store_write(OP_WRITE_BIAS, $urandom_range(0, BIAS_DEPTH - 1));
         end else begin
            case ($urandom_range(0, 3))
               0:       store_write(OP_WRITE_WEIGHT, $urandom_range(0, 65535));
               1:       store_write(OP_WRITE_BIAS, $urandom_range(0, 65535));
               2:       store_write(OP_WRITE_ACTIVATION, $urandom_range(0, 65535));
               default: request_pixel($urandom_range(0, 15), $urandom_range(0, 63),
                                      $urandom_range(0, 63));
            endcase
         end
      end
   endtask

   initial begin
      int i;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: requests outside the map, writes past and at the ends of the stores
      request_pixel(1, 0, 0);
      request_pixel(0, 62, 0);
      request_pixel(0, 0, 62);
      request_pixel(15, 63, 63);
      store_value(OP_WRITE_WEIGHT, WEIGHT_DEPTH, 16'h7FFF, $urandom);
      store_value(OP_WRITE_WEIGHT, 65535, 16'h8000, $urandom);
      store_value(OP_WRITE_BIAS, BIAS_DEPTH, 16'($urandom), 32'h7FFF_FFFF);
      store_value(OP_WRITE_BIAS, 65535, 16'($urandom), 32'h8000_0000);
      store_value(OP_WRITE_ACTIVATION, 65535, 16'h7FFF, $urandom);
      store_value(OP_WRITE_BIAS, 0, 16'($urandom), 32'h8000_0000);
      store_value(OP_WRITE_BIAS, 15, 16'($urandom), 32'h7FFF_FFFF);
      settle(20);
      write_reg(CSR_SPARE, $urandom, 7);

      // Single tap: most negative weight times most negative activation on the bias floor
      set_geometry(1, 1, 1, 1, 0, 64, 64);
      store_value(OP_WRITE_WEIGHT, 0, 16'h8000, $urandom);
      store_value(OP_WRITE_ACTIVATION, 4095, 16'h8000, $urandom);
      request_pixel(0, 63, 63);
      store_value(OP_WRITE_WEIGHT, WEIGHT_DEPTH - 1, 16'h7FFF, $urandom);
      request_pixel(0, 0, 0);

      // Largest kernel loop: all channels, widest kernel, stride and padding round one pixel
      set_geometry(16, 16, 7, 4, 3, 1, 1);
      request_pixel(15, 0, 0);
      request_pixel(0, 0, 0);
      request_pixel($urandom_range(0, 15), 0, 0);
      request_pixel(0, 1, 0);

      // All channels with a single tap
      set_geometry(16, 16, 1, 1, 0, 64, 64);
      for (i = 0; i < 4; i++)
         pixel_somewhere();

      // One pixel inside a wide zero border
      set_geometry(1, 1, 1, 1, 3, 1, 1);
      for (i = 0; i < 10; i++)
         pixel_somewhere();
      request_pixel(0, 7, 0);

      foreach (odd_geoms[g]) begin
         set_geometry(odd_geoms[g][0], odd_geoms[g][1], odd_geoms[g][2], odd_geoms[g][3],
                      odd_geoms[g][4], odd_geoms[g][5], odd_geoms[g][6]);
         pixel_somewhere();
         pixel_somewhere();
      end

      // Random small geometries with random traffic
      for (i = 0; i < 8; i++) begin
         set_geometry($urandom_range(1, 3), $urandom_range(1, 4), $urandom_range(1, 3),
                      $urandom_range(1, 4), $urandom_range(0, 3), $urandom_range(1, 8),
                      $urandom_range(1, 8));
         random_traffic(6);
      end

      // Back to the reset geometry
      set_geometry(1, 1, 3, 1, 0, 64, 64);
      random_traffic(6);

      settle(1000);
      $display("Covered %0d request transfers, %0d of them computes, over %0d geometries.",
               sent_count, compute_count, setting_count);
      $display("Checked %0d results, %0d of them with out-of-range status.",
               checked_count, reject_count);
      if (mismatch_count == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// File: conv2d_direct_forward_core.f
src/cdf_pkg.sv
src/cdf_ram.sv
src/cdf_ctrl.sv
src/cdf_datapath.sv
src/conv2d_direct_forward_core.sv
sim/conv2d_checker.sv
sim/tb.sv
